[design/rvx_pkg.sv]
// Shared types and constants for the RISC-V base-integer execute block.
// Used by rvx_regfile, rvx_exec and riscv_base_integer_execute_top.
`default_nettype none
package rvx_pkg;

    localparam int XLEN     = 64;
    localparam int NUM_REGS = 32;
    localparam int REG_AW   = 5;

    // Major opcodes.
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM32  = 7'b0011011;
    localparam logic [6:0] OP_REG32  = 7'b0111011;
    localparam logic [6:0] OP_FENCE  = 7'b0001111;

    localparam logic [6:0] F7_ALT    = 7'b0100000;

    // ALU funct3 codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Branch funct3 codes.
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // Load width codes (funct3).
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_D  = 3'd3;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;
    localparam logic [2:0] LD_WU = 3'd6;
    localparam logic [2:0] LD_XX = 3'd7;

    // Memory request codes.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic ACT_EXEC = 1'b0;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction_word;
        logic [63:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mem_request;
        logic [63:0] mem_address;
        logic [1:0]  mem_size;
        logic [63:0] mem_write_data;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic [63:0] next_pc;
        logic        illegal;
        logic        load_pending;
    } out_item_t;

    // State updates produced by the execute stage.
    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_waddr;
        logic [63:0] rf_wdata;
        logic [63:0] pc_next;
        logic        pend_valid;
        logic [4:0]  pend_dest;
        logic [2:0]  pend_width;
    } ex_upd_t;

endpackage
`default_nettype wire

[design/rvx_regfile.sv]
// Register file memory: 32 x 64, two registered read ports, one write port.
// Depends on rvx_pkg for sizes.
`default_nettype none
module rvx_regfile #(
    parameter int DEPTH = rvx_pkg::NUM_REGS,
    parameter int AW    = rvx_pkg::REG_AW,
    parameter int DW    = rvx_pkg::XLEN
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] raddr1,
    input  wire logic [AW-1:0] raddr2,
    output logic [DW-1:0]      rdata1,
    output logic [DW-1:0]      rdata2,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    d1_reg, d2_reg;
    logic             v1_reg, v2_reg;

    // Array write.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Written flags; an unwritten entry reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Registered reads with bypass of a write at the same edge.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && waddr == raddr1) begin
                d1_reg <= wdata;
                v1_reg <= 1'b1;
            end else begin
                d1_reg <= mem[raddr1];
                v1_reg <= vld_reg[raddr1];
            end
            if (we && waddr == raddr2) begin
                d2_reg <= wdata;
                v2_reg <= 1'b1;
            end else begin
                d2_reg <= mem[raddr2];
                v2_reg <= vld_reg[raddr2];
            end
        end
    end

    assign rdata1 = v1_reg ? d1_reg : '0;
    assign rdata2 = v2_reg ? d2_reg : '0;

endmodule
`default_nettype wire

[design/rvx_exec.sv]
// Decode and execute logic for one item: ALU, branches, loads, stores, load return.
// Depends on rvx_pkg for the item types, opcodes and function codes.
`default_nettype none
module rvx_exec (
    input  wire rvx_pkg::in_item_t item,
    input  wire logic [63:0]       rs1_val,
    input  wire logic [63:0]       rs2_val,
    input  wire logic [63:0]       pc,
    input  wire logic              xlen64,
    input  wire logic              pend_valid,
    input  wire logic [4:0]        pend_dest,
    input  wire logic [2:0]        pend_width,
    output rvx_pkg::out_item_t     res,
    output rvx_pkg::ex_upd_t       upd
);

    function automatic logic [63:0] sx32(input logic [63:0] v);
        sx32 = {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] alu(input logic [2:0] f3, input logic sub,
                                        input logic sra, input logic [63:0] a,
                                        input logic [63:0] b, input logic word);
        logic [5:0]  sh;
        logic [63:0] r;
        logic [63:0] aw;
        sh = word ? {1'b0, b[4:0]} : b[5:0];
        aw = word ? (sra ? sx32(a) : {32'b0, a[31:0]}) : a;
        unique case (f3)
            rvx_pkg::F3_ADD:  r = sub ? a - b : a + b;
            rvx_pkg::F3_SLL:  r = a << sh;
            rvx_pkg::F3_SLT:  r = {63'b0, $signed(a) < $signed(b)};
            rvx_pkg::F3_SLTU: r = {63'b0, a < b};
            rvx_pkg::F3_XOR:  r = a ^ b;
            rvx_pkg::F3_SRL:  r = sra ? 64'($signed(aw) >>> sh) : aw >> sh;
            rvx_pkg::F3_OR:   r = a | b;
            default:          r = a & b;
        endcase
        alu = word ? sx32(r) : r;
    endfunction

    logic [31:0] w;
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [63:0] npc, val, addr, wdata, ld_v;
    logic [1:0]  req, size;
    logic        wr, ill, taken, arith, alt;

    assign w   = item.instruction_word;
    assign op  = w[6:0];
    assign rd  = w[11:7];
    assign f3  = w[14:12];
    assign rs1 = w[19:15];
    assign rs2 = w[24:20];
    assign f7  = w[31:25];
    assign alt = (f7 == rvx_pkg::F7_ALT);

    assign imm_i = {{52{w[31]}}, w[31:20]};
    assign imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = {{32{w[31]}}, w[31:12], 12'b0};
    assign imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    // Operands: x0 reads zero, RV32 mode sign-extends from bit 31.
    always_comb begin
        a = (rs1 != 5'd0) ? rs1_val : 64'd0;
        b = (rs2 != 5'd0) ? rs2_val : 64'd0;
        if (!xlen64) begin
            a = sx32(a);
            b = sx32(b);
        end
    end

    // Instruction decode and execute.
    always_comb begin
        npc   = pc + 64'd4;
        val   = '0;
        addr  = '0;
        wdata = '0;
        req   = rvx_pkg::MEM_NONE;
        size  = 2'd0;
        wr    = 1'b0;
        ill   = 1'b0;
        taken = 1'b0;
        arith = xlen64 ? (f7[6:1] == rvx_pkg::F7_ALT[6:1]) : alt;
        unique case (op)
            rvx_pkg::OP_LUI: begin
                wr = 1'b1; val = imm_u;
            end
            rvx_pkg::OP_AUIPC: begin
                wr = 1'b1; val = pc + imm_u;
            end
            rvx_pkg::OP_JAL: begin
                wr = 1'b1; val = pc + 64'd4; npc = pc + imm_j;
            end
            rvx_pkg::OP_JALR: begin
                if (f3 != 3'd0) begin
                    ill = 1'b1;
                end else begin
                    wr = 1'b1; val = pc + 64'd4; npc = (a + imm_i) & ~64'd1;
                end
            end
            rvx_pkg::OP_BRANCH: begin
                unique case (f3)
                    rvx_pkg::BR_EQ:  taken = (a == b);
                    rvx_pkg::BR_NE:  taken = (a != b);
                    rvx_pkg::BR_LT:  taken = $signed(a) < $signed(b);
                    rvx_pkg::BR_GE:  taken = !($signed(a) < $signed(b));
                    rvx_pkg::BR_LTU: taken = (a < b);
                    rvx_pkg::BR_GEU: taken = (a >= b);
                    default:         ill = 1'b1;
                endcase
                if (taken) npc = pc + imm_b;
            end
            rvx_pkg::OP_LOAD: begin
                if (f3 == rvx_pkg::LD_XX ||
                    (!xlen64 && (f3 == rvx_pkg::LD_D || f3 == rvx_pkg::LD_WU))) begin
                    ill = 1'b1;
                end else begin
                    req = rvx_pkg::MEM_READ; addr = a + imm_i; size = f3[1:0];
                end
            end
            rvx_pkg::OP_STORE: begin
                if (f3[2] || (!xlen64 && f3 == rvx_pkg::LD_D)) begin
                    ill = 1'b1;
                end else begin
                    req = rvx_pkg::MEM_WRITE; addr = a + imm_s; size = f3[1:0];
                    wdata = b;
                end
            end
            rvx_pkg::OP_IMM: begin
                wr = 1'b1; val = alu(f3, 1'b0, arith, a, imm_i, !xlen64);
            end
            rvx_pkg::OP_REG: begin
                wr = 1'b1; val = alu(f3, alt, alt, a, b, !xlen64);
            end
            rvx_pkg::OP_IMM32: begin
                if (!xlen64 || !(f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SLL ||
                                 f3 == rvx_pkg::F3_SRL)) begin
                    ill = 1'b1;
                end else begin
                    wr = 1'b1; val = alu(f3, 1'b0, alt, a, imm_i, 1'b1);
                end
            end
            rvx_pkg::OP_REG32: begin
                if (!xlen64 || !(f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SLL ||
                                 f3 == rvx_pkg::F3_SRL)) begin
                    ill = 1'b1;
                end else begin
                    wr = 1'b1; val = alu(f3, alt, alt, a, b, 1'b1);
                end
            end
            rvx_pkg::OP_FENCE: begin
            end
            default: ill = 1'b1;
        endcase
        if (!xlen64) begin
            val  = sx32(val);
            npc  = sx32(npc);
            addr = sx32(addr);
        end
    end

    // Extension of returned load data.
    always_comb begin
        unique case (pend_width)
            rvx_pkg::LD_B:  ld_v = {{56{item.load_data[7]}}, item.load_data[7:0]};
            rvx_pkg::LD_H:  ld_v = {{48{item.load_data[15]}}, item.load_data[15:0]};
            rvx_pkg::LD_W:  ld_v = sx32(item.load_data);
            rvx_pkg::LD_D:  ld_v = item.load_data;
            rvx_pkg::LD_BU: ld_v = {56'b0, item.load_data[7:0]};
            rvx_pkg::LD_HU: ld_v = {48'b0, item.load_data[15:0]};
            rvx_pkg::LD_WU: ld_v = {32'b0, item.load_data[31:0]};
            default:        ld_v = '0;
        endcase
        if (!xlen64) ld_v = sx32(ld_v);
    end

    // Result and state update selection.
    always_comb begin
        res            = '0;
        res.next_pc    = pc;
        upd.rf_we      = 1'b0;
        upd.rf_waddr   = rd;
        upd.rf_wdata   = val;
        upd.pc_next    = pc;
        upd.pend_valid = pend_valid;
        upd.pend_dest  = pend_dest;
        upd.pend_width = pend_width;
        if (item.action != rvx_pkg::ACT_EXEC) begin
            if (pend_valid) begin
                upd.pend_valid = 1'b0;
                upd.rf_waddr   = pend_dest;
                upd.rf_wdata   = ld_v;
                if (pend_dest != 5'd0) begin
                    upd.rf_we     = 1'b1;
                    res.reg_write = 1'b1;
                    res.reg_index = pend_dest;
                    res.reg_value = ld_v;
                end
            end
        end else if (pend_valid) begin
            res.load_pending = 1'b1;
        end else if (ill) begin
            res.illegal = 1'b1;
        end else begin
            if (wr && rd != 5'd0) begin
                upd.rf_we     = 1'b1;
                res.reg_write = 1'b1;
                res.reg_index = rd;
                res.reg_value = val;
            end
            if (req == rvx_pkg::MEM_READ) begin
                upd.pend_valid = 1'b1;
                upd.pend_dest  = rd;
                upd.pend_width = f3;
            end
            res.mem_request    = req;
            res.mem_address    = addr;
            res.mem_size       = size;
            res.mem_write_data = wdata;
            res.next_pc        = npc;
            upd.pc_next        = npc;
            res.load_pending   = (req == rvx_pkg::MEM_READ);
        end
    end

endmodule
`default_nettype wire

[design/riscv_base_integer_execute_top.sv]
// Top level of the RISC-V base-integer execute block.
// Instantiates rvx_regfile and rvx_exec; types and constants from rvx_pkg.
//
// Usage: an input transfer on s_valid/s_ready carries either an instruction to
// execute or the data returned for the pending load. Each transfer produces
// exactly one result transfer on m_valid/m_ready, in order.
// The transfer edge captures the item in the execute stage input register and reads
// rs1/rs2 from the register file memory; when that stage advances, it executes the
// item, writes back and loads the output register.
// Throughput is one item per cycle while results are taken; a write back at the same
// edge as the next read is bypassed inside the register file.
// When m_ready is low the result holds in the output register; the execute
// stage keeps one more item, then s_ready falls until the result is taken.
// Synchronous active-low reset clears pc, pending load state, written flags
// of the register file (all registers read zero) and sets xlen64 to RV64.
// cfg_wr_en writes xlen64 at the clock edge; write it only while idle.
`default_nettype none
module riscv_base_integer_execute_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rvx_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rvx_pkg::out_item_t     m_data
);

    logic               xlen64_reg;
    logic [63:0]        pc_reg;
    logic               pend_valid_reg;
    logic [4:0]         pend_dest_reg;
    logic [2:0]         pend_width_reg;
    logic               ex_valid_reg;
    rvx_pkg::in_item_t  ex_item_reg;
    logic               m_valid_reg;
    rvx_pkg::out_item_t m_data_reg;

    logic               s_xfer, ex_advance;
    logic [63:0]        rs1_val, rs2_val;
    rvx_pkg::out_item_t ex_res;
    rvx_pkg::ex_upd_t   ex_upd;

    // Handshake control.
    assign ex_advance = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !ex_valid_reg || ex_advance;
    assign s_xfer     = s_valid && s_ready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xlen64_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            xlen64_reg <= cfg_wr_data;
        end
    end

    rvx_regfile #(
        .DEPTH (rvx_pkg::NUM_REGS),
        .AW    (rvx_pkg::REG_AW),
        .DW    (rvx_pkg::XLEN)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .raddr1  (s_data.instruction_word[15 +: rvx_pkg::REG_AW]),
        .raddr2  (s_data.instruction_word[20 +: rvx_pkg::REG_AW]),
        .rdata1  (rs1_val),
        .rdata2  (rs2_val),
        .we      (ex_advance && ex_upd.rf_we),
        .waddr   (ex_upd.rf_waddr),
        .wdata   (ex_upd.rf_wdata)
    );

    rvx_exec u_exec (
        .item       (ex_item_reg),
        .rs1_val    (rs1_val),
        .rs2_val    (rs2_val),
        .pc         (pc_reg),
        .xlen64     (xlen64_reg),
        .pend_valid (pend_valid_reg),
        .pend_dest  (pend_dest_reg),
        .pend_width (pend_width_reg),
        .res        (ex_res),
        .upd        (ex_upd)
    );

    // Execute stage input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            ex_valid_reg <= 1'b1;
        end else if (ex_advance) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ex_item_reg <= s_data;
        end
    end

    // Architectural state commit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            pend_dest_reg  <= '0;
            pend_width_reg <= '0;
        end else if (ex_advance) begin
            pc_reg         <= ex_upd.pc_next;
            pend_valid_reg <= ex_upd.pend_valid;
            pend_dest_reg  <= ex_upd.pend_dest;
            pend_width_reg <= ex_upd.pend_width;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ex_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_advance) begin
            m_data_reg <= ex_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
